>>> hdl/zss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zss_pkg;

  // field and register widths
  localparam int MODE_W     = 2;
  localparam int ZONE_W     = 8;
  localparam int SPEED_W    = 16;
  localparam int TIME_W     = 32;
  localparam int NZ_W       = 5;
  localparam int TO_W       = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // zone count is carried wide enough for MAX_ZONES up to 256
  localparam int CNT_W = 9;

  localparam int DEF_MAX_ZONES = 16;

  localparam logic [NZ_W-1:0] ZONE_CNT_RST   = NZ_W'(4);
  localparam logic [TO_W-1:0] HB_TIMEOUT_RST = TO_W'(500);

  // quotient bits of zone * 2^15 / (n - 1); zone <= n - 1 keeps it at 16 bits
  localparam int QUO_STEPS = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_CNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HB_TIMEOUT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    EV_ZONE      = 2'd0,
    EV_COLLAB    = 2'd1,
    EV_HEARTBEAT = 2'd2,
    EV_TICK      = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_RUNNING   = 2'd1,
    ST_PAUSED    = 2'd2,
    ST_NONCOLLAB = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_DONE
  } seq_t;

endpackage

`default_nettype wire

>>> hdl/zone_speed_supervisor.sv
// Zone speed supervisor: tracks idle / running / paused / noncollab from a
// stream of events and issues speed and pause/resume commands.
// Input channel: item_valid / item_stall with mode, zone, collaborative and
// time_ms. Output channel: result_valid / result_stall with speed_valid,
// speed (Q1.15), pause_valid, paused and fsm_state. Every input beat gives
// exactly one result beat.
// Timing: a zone report that sets a new speed runs the serial divider, one
// quotient bit per cycle, and then passes through the done state to the output
// register. Every other event goes from the input beat through the done state
// to the output register. The next input beat is taken once the sequencer is
// back in idle, after the result has been loaded into the output register.
// item_stall is high while an event is in work. A finished result waits in
// the output register; the next input beat is taken meanwhile, but the result
// after it holds until the waiting beat is taken.
// Config port: cfg_write with cfg_index 0 = zone count, 1 = heartbeat_timeout.
// Write only while idle. Reset (rst, synchronous) restores a zone count of 4,
// timeout 500 ms, state idle and a disarmed watchdog; no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module zone_speed_supervisor #(
  parameter int MAX_ZONES = zss_pkg::DEF_MAX_ZONES
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // config
  input  wire logic                              cfg_write,
  input  wire logic [zss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [zss_pkg::CFG_DATA_W-1:0]    cfg_data,
  // event beats
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire logic [zss_pkg::MODE_W-1:0]        mode,
  input  wire logic [zss_pkg::ZONE_W-1:0]        zone,
  input  wire logic                              collaborative,
  input  wire logic [zss_pkg::TIME_W-1:0]        time_ms,
  // result beats
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic                                   speed_valid,
  output logic [zss_pkg::SPEED_W-1:0]            speed,
  output logic                                   pause_valid,
  output logic                                   paused,
  output logic [1:0]                             fsm_state
);

  localparam int RZ_W = (MAX_ZONES > 2) ? $clog2(MAX_ZONES) : 1;
  localparam logic [zss_pkg::CNT_W-1:0] MAX_CNT = zss_pkg::CNT_W'(MAX_ZONES);
  localparam logic [zss_pkg::CNT_W-1:0] MIN_CNT = zss_pkg::CNT_W'(2);

  // config registers
  logic [zss_pkg::NZ_W-1:0] zone_cnt_cfg;
  logic [zss_pkg::TO_W-1:0] heartbeat_timeout;

  // supervisor state
  zss_pkg::state_t          mode_state, mode_state_next;
  logic [RZ_W-1:0]          running_zone;
  logic [zss_pkg::TIME_W-1:0] last_heartbeat;
  logic                     heartbeat_seen;

  // sequencer
  zss_pkg::seq_t            seq, seq_next;
  logic                     accept;
  logic                     div_start;
  logic                     div_done;
  logic                     out_load;
  logic [zss_pkg::SPEED_W-1:0] quotient;

  // decoded command for the event in work
  logic                     cmd_speed, cmd_pause, cmd_paused;
  logic                     rz_we, hb_we;
  logic                     pend_speed, pend_pause, pend_paused;
  zss_pkg::state_t          pend_state;

  // clamped zone count and derived terms
  logic [zss_pkg::CNT_W-1:0]  nz_ext;
  logic [zss_pkg::CNT_W-1:0]  zcount;
  logic [zss_pkg::CNT_W-1:0]  zdiv;
  logic                       zone_ok;
  logic                       same_zone;
  logic [zss_pkg::TIME_W:0]   hb_limit;
  logic                       late;

  assign accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_cnt_cfg      <= zss_pkg::ZONE_CNT_RST;
      heartbeat_timeout <= zss_pkg::HB_TIMEOUT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        zss_pkg::CFG_ZONE_CNT:   zone_cnt_cfg <= cfg_data[zss_pkg::NZ_W-1:0];
        zss_pkg::CFG_HB_TIMEOUT: heartbeat_timeout <= cfg_data[zss_pkg::TO_W-1:0];
        default: ;
      endcase
    end
  end

  // zone count below 2 acts as 2, above MAX_ZONES as MAX_ZONES
  always_comb begin
    nz_ext = zss_pkg::CNT_W'(zone_cnt_cfg);
    if (nz_ext < MIN_CNT) begin
      zcount = MIN_CNT;
    end else if (nz_ext > MAX_CNT) begin
      zcount = MAX_CNT;
    end else begin
      zcount = nz_ext;
    end
    zdiv      = zcount - 1'b1;
    zone_ok   = zss_pkg::CNT_W'(zone) < zcount;
    same_zone = zone == zss_pkg::ZONE_W'(running_zone);
    // late tick: time_ms > last_heartbeat + timeout, no wrap
    hb_limit  = {1'b0, last_heartbeat} + (zss_pkg::TIME_W + 1)'(heartbeat_timeout);
    late      = {1'b0, time_ms} > hb_limit;
  end

  // event decode against the current state
  always_comb begin
    cmd_speed       = 1'b0;
    cmd_pause       = 1'b0;
    cmd_paused      = 1'b0;
    rz_we           = 1'b0;
    hb_we           = 1'b0;
    mode_state_next = mode_state;
    case (mode)
      zss_pkg::EV_ZONE: begin
        if (mode_state != zss_pkg::ST_NONCOLLAB && zone_ok) begin
          if (zone == '0) begin
            if (mode_state != zss_pkg::ST_PAUSED) begin
              mode_state_next = zss_pkg::ST_PAUSED;
              cmd_pause       = 1'b1;
              cmd_paused      = 1'b1;
            end
          end else if (!(mode_state == zss_pkg::ST_RUNNING && same_zone)) begin
            cmd_speed = 1'b1;
            if (mode_state == zss_pkg::ST_PAUSED) begin
              cmd_pause = 1'b1;   // resume
            end
            mode_state_next = zss_pkg::ST_RUNNING;
            rz_we           = 1'b1;
          end
        end
      end
      zss_pkg::EV_COLLAB: begin
        if (!collaborative && mode_state != zss_pkg::ST_NONCOLLAB) begin
          mode_state_next = zss_pkg::ST_NONCOLLAB;
          cmd_pause       = 1'b1;
          cmd_paused      = 1'b1;
        end else if (collaborative && mode_state == zss_pkg::ST_NONCOLLAB) begin
          mode_state_next = zss_pkg::ST_IDLE;
          cmd_pause       = 1'b1;
        end
      end
      zss_pkg::EV_HEARTBEAT: begin
        hb_we = 1'b1;
      end
      zss_pkg::EV_TICK: begin
        if (heartbeat_seen && late &&
            (mode_state inside {zss_pkg::ST_IDLE, zss_pkg::ST_RUNNING})) begin
          mode_state_next = zss_pkg::ST_PAUSED;
          cmd_pause       = 1'b1;
          cmd_paused      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // state commits at the input beat; only the speed value comes later
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state     <= zss_pkg::ST_IDLE;
      running_zone   <= '0;
      last_heartbeat <= '0;
      heartbeat_seen <= 1'b0;
    end else if (accept) begin
      mode_state <= mode_state_next;
      if (rz_we) begin
        running_zone <= zone[RZ_W-1:0];
      end
      if (hb_we) begin
        last_heartbeat <= time_ms;
        heartbeat_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_speed  <= cmd_speed;
      pend_pause  <= cmd_pause;
      pend_paused <= cmd_paused;
      pend_state  <= mode_state_next;
    end
  end

  zss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .zone     (zone),
    .divisor  (zdiv[zss_pkg::ZONE_W-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  // sequencer: next state
  always_comb begin
    seq_next = seq;
    case (seq)
      zss_pkg::SEQ_IDLE: begin
        if (item_valid) begin
          seq_next = cmd_speed ? zss_pkg::SEQ_DIV : zss_pkg::SEQ_DONE;
        end
      end
      zss_pkg::SEQ_DIV: begin
        if (div_done) begin
          seq_next = zss_pkg::SEQ_DONE;
        end
      end
      zss_pkg::SEQ_DONE: begin
        if (!result_valid || !result_stall) begin
          seq_next = zss_pkg::SEQ_IDLE;
        end
      end
      default: seq_next = zss_pkg::SEQ_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    item_stall = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (seq)
      zss_pkg::SEQ_IDLE: begin
        item_stall = 1'b0;
        div_start  = item_valid && cmd_speed;
      end
      zss_pkg::SEQ_DONE: begin
        out_load = !result_valid || !result_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= zss_pkg::SEQ_IDLE;
    end else begin
      seq <= seq_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      speed_valid <= pend_speed;
      speed       <= pend_speed ? quotient : '0;
      pause_valid <= pend_pause;
      paused      <= pend_paused;
      fsm_state   <= pend_state;
    end
  end

endmodule

`default_nettype wire

>>> hdl/zss_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: quotient = floor(zone * 2^15 / divisor), one bit a cycle.
// Requires zone <= divisor.
module zss_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [zss_pkg::ZONE_W-1:0]    zone,
  input  wire logic [zss_pkg::ZONE_W-1:0]    divisor,
  output logic                               done,
  output logic [zss_pkg::SPEED_W-1:0]        quotient
);

  localparam int STEP_W = $clog2(zss_pkg::QUO_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(zss_pkg::QUO_STEPS - 1);

  logic                          busy;
  logic [STEP_W-1:0]             step;
  logic [zss_pkg::ZONE_W-1:0]    rem;
  logic [zss_pkg::ZONE_W-1:0]    dvs;
  logic [zss_pkg::ZONE_W:0]      trial;
  logic [zss_pkg::ZONE_W:0]      diff;
  logic                          ge;

  // first step weighs 2^15 directly; later steps shift the remainder
  always_comb begin
    trial = (step == '0) ? {1'b0, rem} : {rem, 1'b0};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  assign done = busy && (step == LAST_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= zone;
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[zss_pkg::ZONE_W-1:0] : trial[zss_pkg::ZONE_W-1:0];
      quotient <= {quotient[zss_pkg::SPEED_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

>>> hdl/zss_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module zss_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           item_valid,
  input wire logic                           item_stall,
  input wire logic                           result_valid,
  input wire logic                           result_stall,
  input wire logic                           speed_valid,
  input wire logic [zss_pkg::SPEED_W-1:0]    speed,
  input wire logic                           pause_valid,
  input wire logic                           paused,
  input wire logic [1:0]                     fsm_state
);

  // a held result beat stays
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // one event in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input beat taken while an event is in work");

  a_speed_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && speed_valid |->
      fsm_state == zss_pkg::ST_RUNNING && speed <= zss_pkg::SPEED_W'(32768) && speed != '0)
    else $error("speed command outside running or out of range");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (speed_valid || speed == '0) && (pause_valid || !paused))
    else $error("field set without its valid flag");

  a_pause_state: assert property (@(posedge clk) disable iff (rst)
    result_valid && pause_valid && paused |->
      fsm_state == zss_pkg::ST_PAUSED || fsm_state == zss_pkg::ST_NONCOLLAB)
    else $error("pause issued but state not paused or noncollab");

endmodule

bind zone_speed_supervisor zss_checker u_zss_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .speed_valid  (speed_valid),
  .speed        (speed),
  .pause_valid  (pause_valid),
  .paused       (paused),
  .fsm_state    (fsm_state)
);

`default_nettype wire
